>>> design/bcs_pkg.sv
// Shared types and constants for the barrier cycle sequencer.
// No dependencies; imported by every module of the block.
package bcs_pkg;

    // Field widths
    localparam int unsigned MsW    = 16;
    localparam int unsigned PhaseW = 3;
    localparam int unsigned OutcW  = 2;
    localparam int unsigned CfgIdxW = 3;

    // Phase codes
    localparam logic [PhaseW-1:0] PH_IDLE       = 3'd0;
    localparam logic [PhaseW-1:0] PH_OPEN_PULSE = 3'd1;
    localparam logic [PhaseW-1:0] PH_OPENING    = 3'd2;
    localparam logic [PhaseW-1:0] PH_HOLD       = 3'd3;
    localparam logic [PhaseW-1:0] PH_SCAN       = 3'd4;
    localparam logic [PhaseW-1:0] PH_BACKOFF    = 3'd5;
    localparam logic [PhaseW-1:0] PH_CLOSING    = 3'd6;
    localparam logic [PhaseW-1:0] PH_REOPEN     = 3'd7;

    // Outcome codes
    localparam logic [OutcW-1:0] OUT_NONE    = 2'd0;
    localparam logic [OutcW-1:0] OUT_PASSED  = 2'd1;
    localparam logic [OutcW-1:0] OUT_REFUSED = 2'd2;
    localparam logic [OutcW-1:0] OUT_ABORTED = 2'd3;

    // Item operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_RELAY_PULSE     = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_OPENING_TRAVEL  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_OPEN_HOLD       = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_CLEARANCE       = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_CLOSING_TRAVEL  = 3'd4;

    // Reset values and fixed times, milliseconds
    localparam logic [MsW-1:0] RST_RELAY_PULSE    = 16'd1000;
    localparam logic [MsW-1:0] RST_OPENING_TRAVEL = 16'd3000;
    localparam logic [MsW-1:0] RST_OPEN_HOLD      = 16'd5000;
    localparam logic [MsW-1:0] RST_CLEARANCE      = 16'd1500;
    localparam logic [MsW-1:0] RST_CLOSING_TRAVEL = 16'd3000;
    localparam logic [MsW-1:0] BACKOFF_MS         = 16'd100;

    typedef struct packed {
        logic op;
        logic beam_blocked;
    } t_in_item;

    typedef struct packed {
        logic              request_open;
        logic              request_close;
        logic              green_light;
        logic [PhaseW-1:0] phase;
        logic [OutcW-1:0]  outcome;
        logic              obstruction_warning;
    } t_out_item;

    typedef struct packed {
        logic [MsW-1:0] relay_pulse_ms;
        logic [MsW-1:0] opening_travel_ms;
        logic [MsW-1:0] open_hold_ms;
        logic [MsW-1:0] clearance_ms;
        logic [MsW-1:0] closing_travel_ms;
    } t_cfg;

endpackage

>>> design/bcs_cfg_regs.sv
// Configuration register file of the barrier cycle sequencer.
// Depends on bcs_pkg for the register indexes, reset values and t_cfg.
module bcs_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bcs_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [bcs_pkg::MsW-1:0]      i_cfg_data,
    output bcs_pkg::t_cfg                o_cfg
);
    import bcs_pkg::*;

    t_cfg r_cfg;

    // Load reset values, then take writes by index; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.relay_pulse_ms    <= RST_RELAY_PULSE;
            r_cfg.opening_travel_ms <= RST_OPENING_TRAVEL;
            r_cfg.open_hold_ms      <= RST_OPEN_HOLD;
            r_cfg.clearance_ms      <= RST_CLEARANCE;
            r_cfg.closing_travel_ms <= RST_CLOSING_TRAVEL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RELAY_PULSE:    r_cfg.relay_pulse_ms    <= i_cfg_data;
                REG_OPENING_TRAVEL: r_cfg.opening_travel_ms <= i_cfg_data;
                REG_OPEN_HOLD:      r_cfg.open_hold_ms      <= i_cfg_data;
                REG_CLEARANCE:      r_cfg.clearance_ms      <= i_cfg_data;
                REG_CLOSING_TRAVEL: r_cfg.closing_travel_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/bcs_core.sv
// Phase sequencer of the barrier cycle: phase, elapsed-time counter, outcome.
// Depends on bcs_pkg; produces the result of each accepted item combinationally.
module bcs_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  bcs_pkg::t_in_item  i_item,
    input  bcs_pkg::t_cfg      i_cfg,
    output bcs_pkg::t_out_item o_result
);
    import bcs_pkg::*;

    logic [PhaseW-1:0] r_phase, n_phase;
    logic [MsW-1:0]    r_elapsed, n_elapsed;
    logic [OutcW-1:0]  r_outcome, n_outcome;
    logic              n_warn;
    logic [MsW-1:0]    inc_ms;
    logic [MsW-1:0]    limit_ms;
    logic              done;

    // Select the time limit of the current phase
    always_comb begin
        case (r_phase)
            PH_OPEN_PULSE, PH_REOPEN: limit_ms = i_cfg.relay_pulse_ms;
            PH_OPENING:               limit_ms = i_cfg.opening_travel_ms;
            PH_HOLD:                  limit_ms = i_cfg.open_hold_ms;
            PH_SCAN:                  limit_ms = i_cfg.clearance_ms;
            PH_BACKOFF:               limit_ms = BACKOFF_MS;
            PH_CLOSING:               limit_ms = i_cfg.closing_travel_ms;
            default:                  limit_ms = '0;
        endcase
    end

    // Count one tick, wrapping at 16 bits
    assign inc_ms = r_elapsed + 16'd1;
    assign done   = (inc_ms >= limit_ms);

    // Advance the phase for one item
    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_outcome = r_outcome;
        n_warn    = 1'b0;
        if (i_item.op == OP_START) begin
            if (r_phase == PH_IDLE) begin
                if (i_item.beam_blocked) begin
                    n_outcome = OUT_REFUSED;
                end else begin
                    n_phase   = PH_OPEN_PULSE;
                    n_elapsed = '0;
                end
            end
        end else if (r_phase != PH_IDLE) begin
            n_elapsed = done ? '0 : inc_ms;
            case (r_phase)
                PH_OPEN_PULSE: if (done) n_phase = PH_OPENING;
                PH_OPENING:    if (done) n_phase = PH_HOLD;
                PH_HOLD:       if (done) n_phase = PH_SCAN;
                PH_SCAN: begin
                    if (i_item.beam_blocked) begin
                        n_warn    = 1'b1;
                        n_phase   = PH_BACKOFF;
                        n_elapsed = '0;
                    end else if (done) begin
                        n_phase = PH_CLOSING;
                    end
                end
                PH_BACKOFF:    if (done) n_phase = PH_SCAN;
                PH_CLOSING: begin
                    if (i_item.beam_blocked) begin
                        n_phase   = PH_REOPEN;
                        n_elapsed = '0;
                    end else if (done) begin
                        n_phase   = PH_IDLE;
                        n_outcome = OUT_PASSED;
                    end
                end
                PH_REOPEN: begin
                    if (done) begin
                        n_phase   = PH_IDLE;
                        n_outcome = OUT_ABORTED;
                    end
                end
                default: ;
            endcase
        end
    end

    // Hold state between accepted items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_elapsed <= '0;
            r_outcome <= OUT_NONE;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_outcome <= n_outcome;
        end
    end

    // Decode the relay and light outputs from the new state
    always_comb begin
        o_result.request_open  = (n_phase == PH_OPEN_PULSE) || (n_phase == PH_REOPEN);
        o_result.request_close = (n_phase == PH_CLOSING) &&
                                 (n_elapsed < i_cfg.relay_pulse_ms);
        o_result.green_light   = (n_phase != PH_IDLE) && (n_phase != PH_CLOSING);
        o_result.phase         = n_phase;
        o_result.outcome       = n_outcome;
        o_result.obstruction_warning = n_warn;
    end

endmodule

>>> design/barrier_cycle_sequencer.sv
// Barrier cycle sequencer top level: configuration, sequencer core, result register.
// Depends on bcs_pkg, bcs_cfg_regs and bcs_core.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one item per
//   transfer: a one-millisecond tick or a start command, with the sampled beam.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly one
//   result per item: relay requests, light, phase, last outcome and warning.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index with no
//   wait; write only while no item is in flight.
// Timing:
//   The result of an item accepted at one edge is registered and valid after
//   that edge. Throughput is one item per cycle while i_out_ready takes each result,
//   set by the phase and elapsed-time registers, which update once per item.
// Reset and stall:
//   Synchronous active-low reset returns the phase to idle, the counter and
//   outcome to zero, and the registers to their default times.
//   While a result waits on i_out_ready low, o_in_ready drops and the result
//   holds; a new item is taken in the same cycle the waiting result leaves.
module barrier_cycle_sequencer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bcs_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bcs_pkg::t_out_item           o_out_data,
    input  logic                         i_cfg_we,
    input  logic [bcs_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [bcs_pkg::MsW-1:0]      i_cfg_data
);
    import bcs_pkg::*;

    t_cfg      cfg;
    t_out_item result;
    t_out_item r_out_data;
    logic      r_out_valid;
    logic      in_xfer;

    // Accept when the result register is empty or being emptied
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    bcs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bcs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_xfer),
        .i_item   (i_in_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Hold the result until its transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> design/bcs_checker.sv
// Port-level checks for the barrier cycle sequencer, bound to the top level.
// Depends on bcs_pkg for the result type and phase codes.
module bcs_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         o_in_ready,
    input  logic                         o_out_valid,
    input  logic                         i_out_ready,
    input  bcs_pkg::t_out_item           o_out_data
);
    import bcs_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // An empty result register never stalls the input side
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with no result waiting");

    // The close relay is driven only while closing
    a_close_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.request_close |-> o_out_data.phase == PH_CLOSING)
        else $error("close relay outside closing phase");

    // A warning always starts the back-off, and never with a relay driven
    a_warn_backoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.obstruction_warning |->
            o_out_data.phase == PH_BACKOFF && !o_out_data.request_open &&
            !o_out_data.request_close)
        else $error("warning without back-off");

    // Open relay always shows green
    a_open_green: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.request_open |-> o_out_data.green_light)
        else $error("open relay with red light");

endmodule

bind barrier_cycle_sequencer bcs_checker u_bcs_checker (.*);

>>> sim/barrier_cycle_sequencer_tb.sv
// Self-checking testbench for the barrier cycle sequencer: drives ticks and start commands,
// predicts every status transfer with its own sequencer model and checks it field by field.
// Depends on bcs_pkg and barrier_cycle_sequencer.
module barrier_cycle_sequencer_tb;
    import bcs_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int IDLE_PCT       = 9;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_REPORTS    = 40;
    localparam int RESET_TICKS    = 20;
    localparam int PEEK_TICKS     = 6;
    localparam logic [MsW-1:0] MS_MAX = '1;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    t_in_item           in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_out_item          out_data;
    logic               cfg_we    = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [MsW-1:0]     cfg_data  = '0;

    // Sequencer model state, advanced once per accepted item
    t_cfg              timings_q;
    logic [PhaseW-1:0] phase_q;
    logic [MsW-1:0]    elapsed_q;
    logic [OutcW-1:0]  outcome_q;
    logic              item_counted;
    t_out_item         predicted_status[$];
    t_out_item         status_due;

    // Run control and tallies
    logic steady        = 1'b0;
    logic long_hold_req = 1'b0;
    int   hold_left     = 0;
    int   idle_cycles   = 0;
    int   mismatches    = 0;
    int   results_seen  = 0;
    int   effective_items = 0;
    int   passes        = 0;
    int   aborts        = 0;
    int   refusals      = 0;
    int   warnings      = 0;

    barrier_cycle_sequencer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Count one millisecond; clear and report when the limit is reached
    function automatic logic timer_expired(input logic [MsW-1:0] limit);
        elapsed_q = elapsed_q + 1'b1;
        if (elapsed_q >= limit) begin
            elapsed_q = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void enter_phase(input logic [PhaseW-1:0] next_phase);
        phase_q   = next_phase;
        elapsed_q = '0;
    endfunction

    // Apply one item to the model and return the status it leaves behind
    function automatic t_out_item advance_sequencer(input t_in_item item);
        t_out_item status;
        status = '0;
        item_counted = 1'b1;
        if (item.op == OP_START) begin
            if (phase_q != PH_IDLE) begin
                item_counted = 1'b0;
            end else if (item.beam_blocked) begin
                outcome_q = OUT_REFUSED;
                refusals++;
            end else begin
                enter_phase(PH_OPEN_PULSE);
            end
        end else begin
            case (phase_q)
                PH_OPEN_PULSE: begin
                    if (timer_expired(timings_q.relay_pulse_ms)) enter_phase(PH_OPENING);
                end
                PH_OPENING: begin
                    if (timer_expired(timings_q.opening_travel_ms)) enter_phase(PH_HOLD);
                end
                PH_HOLD: begin
                    if (timer_expired(timings_q.open_hold_ms)) enter_phase(PH_SCAN);
                end
                PH_SCAN: begin
                    if (item.beam_blocked) begin
                        status.obstruction_warning = 1'b1;
                        warnings++;
                        enter_phase(PH_BACKOFF);
                    end else if (timer_expired(timings_q.clearance_ms)) begin
                        enter_phase(PH_CLOSING);
                    end
                end
                PH_BACKOFF: begin
                    if (timer_expired(BACKOFF_MS)) enter_phase(PH_SCAN);
                end
                PH_CLOSING: begin
                    if (item.beam_blocked) begin
                        enter_phase(PH_REOPEN);
                    end else if (timer_expired(timings_q.closing_travel_ms)) begin
                        enter_phase(PH_IDLE);
                        outcome_q = OUT_PASSED;
                        passes++;
                    end
                end
                PH_REOPEN: begin
                    if (timer_expired(timings_q.relay_pulse_ms)) begin
                        enter_phase(PH_IDLE);
                        outcome_q = OUT_ABORTED;
                        aborts++;
                    end
                end
                default: begin
                    // a tick while idle does nothing
                    item_counted = 1'b0;
                end
            endcase
        end
        status.request_open  = (phase_q == PH_OPEN_PULSE) || (phase_q == PH_REOPEN);
        status.request_close = (phase_q == PH_CLOSING) &&
                               (elapsed_q < timings_q.relay_pulse_ms);
        status.green_light   = (phase_q != PH_IDLE) && (phase_q != PH_CLOSING);
        status.phase         = phase_q;
        status.outcome       = outcome_q;
        return status;
    endfunction

    function automatic logic [MsW-1:0] random_ms(input int lo);
        if ($urandom_range(99) < 10) return MsW'($urandom_range(60, lo));
        return MsW'($urandom_range(8, lo));
    endfunction

    // Offer one item, hold it until the transfer, then record its prediction
    task automatic send_item(input logic op, input logic beam);
        t_in_item item;
        item.op = op;
        item.beam_blocked = beam;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted_status.push_back(advance_sequencer(item));
        if (item_counted) effective_items++;
    endtask

    task automatic run_until(input logic [PhaseW-1:0] target);
        while (phase_q != target) send_item(OP_TICK, 1'b0);
    endtask

    task automatic finish_cycle();
        run_until(PH_IDLE);
    endtask

    // Stop offering and wait until every predicted status has arrived
    task automatic wait_status_drained();
        in_valid <= 1'b0;
        while (predicted_status.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [MsW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Let the pipeline empty, then write one timing and track it in the model
    task automatic set_timing(input logic [CfgIdxW-1:0] index, input logic [MsW-1:0] value);
        wait_status_drained();
        write_reg(index, value);
        cfg_we <= 1'b0;
        case (index)
            REG_RELAY_PULSE:    timings_q.relay_pulse_ms    = value;
            REG_OPENING_TRAVEL: timings_q.opening_travel_ms = value;
            REG_OPEN_HOLD:      timings_q.open_hold_ms      = value;
            REG_CLEARANCE:      timings_q.clearance_ms      = value;
            REG_CLOSING_TRAVEL: timings_q.closing_travel_ms = value;
            default: ;
        endcase
    endtask

    // Write all five timings wherever the sequencer stands, then one unused index
    task automatic write_timings(input logic [MsW-1:0] pulse, input logic [MsW-1:0] opening,
                                 input logic [MsW-1:0] hold, input logic [MsW-1:0] clearance,
                                 input logic [MsW-1:0] closing);
        set_timing(REG_RELAY_PULSE, pulse);
        set_timing(REG_OPENING_TRAVEL, opening);
        set_timing(REG_OPEN_HOLD, hold);
        set_timing(REG_CLEARANCE, clearance);
        set_timing(REG_CLOSING_TRAVEL, closing);
        // an index past the last register must be dropped
        write_reg(CfgIdxW'($urandom_range(REG_CLOSING_TRAVEL + 1, (1 << CfgIdxW) - 1)),
                  MsW'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Bring the barrier to idle, then load all five timings
    task automatic load_timings(input logic [MsW-1:0] pulse, input logic [MsW-1:0] opening,
                                input logic [MsW-1:0] hold, input logic [MsW-1:0] clearance,
                                input logic [MsW-1:0] closing);
        finish_cycle();
        write_timings(pulse, opening, hold, clearance, closing);
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %0d got %0d", $time, field, want, got);
        end
    endtask

    // Check each status transfer against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (predicted_status.size() == 0) begin
                mismatches++;
                $display("%0t: status expected none got %h", $time, out_data);
            end else begin
                status_due = predicted_status.pop_front();
                compare_field("request_open", status_due.request_open, out_data.request_open);
                compare_field("request_close", status_due.request_close,
                              out_data.request_close);
                compare_field("green_light", status_due.green_light, out_data.green_light);
                compare_field("phase", status_due.phase, out_data.phase);
                compare_field("outcome", status_due.outcome, out_data.outcome);
                compare_field("obstruction_warning", status_due.obstruction_warning,
                              out_data.obstruction_warning);
            end
        end
    end

    // Receiver: random stalls, or one long hold-off on request
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (long_hold_req) begin
            long_hold_req <= 1'b0;
            hold_left     <= LONG_HOLD;
            out_ready     <= 1'b0;
        end else begin
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Drop the run when no transfer happens for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Open on the timings held after reset, then shorten them mid-pulse and finish
    task automatic test_reset_timings();
        send_item(OP_START, 1'b0);
        repeat (RESET_TICKS) send_item(OP_TICK, 1'b0);
        write_timings(30, 2, 2, 3, 4);
        finish_cycle();
    endtask

    task automatic test_directed();
        load_timings(2, 1, 1, 2, 3);
        // ticks in idle change nothing
        send_item(OP_TICK, 1'b0);
        send_item(OP_TICK, 1'b1);
        // start with the beam broken is refused
        send_item(OP_START, 1'b1);
        // start with a clear beam opens; further starts are ignored
        send_item(OP_START, 1'b0);
        send_item(OP_START, 1'b1);
        send_item(OP_START, 1'b0);
        // beam is not looked at during the open pulse
        send_item(OP_TICK, 1'b1);
        run_until(PH_SCAN);
        // break during the scan: warning, back-off, fresh scan
        send_item(OP_TICK, 1'b0);
        send_item(OP_TICK, 1'b1);
        run_until(PH_CLOSING);
        // break while closing: reopen, start ignored, then aborted
        send_item(OP_TICK, 1'b0);
        send_item(OP_TICK, 1'b1);
        send_item(OP_START, 1'b0);
        finish_cycle();
        // clean cycle ends passed
        send_item(OP_START, 1'b0);
        finish_cycle();
    endtask

    task automatic test_extreme_timings();
        // shortest cycle; zero clearance ends after one tick
        load_timings(1, 1, 1, 0, 1);
        send_item(OP_START, 1'b0);
        finish_cycle();
        send_item(OP_START, 1'b0);
        run_until(PH_SCAN);
        send_item(OP_TICK, 1'b1);
        finish_cycle();
        // longest times: run a few ticks into each phase, then cut it short
        load_timings(MS_MAX, MS_MAX, MS_MAX, MS_MAX, MS_MAX);
        send_item(OP_START, 1'b0);
        repeat (PEEK_TICKS) send_item(OP_TICK, 1'b0);
        set_timing(REG_RELAY_PULSE, 1);
        run_until(PH_OPENING);
        repeat (PEEK_TICKS) send_item(OP_TICK, 1'b0);
        set_timing(REG_OPENING_TRAVEL, 1);
        run_until(PH_HOLD);
        repeat (PEEK_TICKS) send_item(OP_TICK, 1'b0);
        set_timing(REG_OPEN_HOLD, 1);
        run_until(PH_SCAN);
        repeat (PEEK_TICKS) send_item(OP_TICK, 1'b0);
        set_timing(REG_RELAY_PULSE, MS_MAX);
        set_timing(REG_CLEARANCE, 0);
        run_until(PH_CLOSING);
        // close relay stays on; break the beam and reopen on the longest pulse
        repeat (PEEK_TICKS) send_item(OP_TICK, 1'b0);
        send_item(OP_TICK, 1'b1);
        repeat (PEEK_TICKS) send_item(OP_TICK, 1'b0);
        set_timing(REG_RELAY_PULSE, 1);
        finish_cycle();
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_receiver_hold();
        load_timings(3, 2, 2, 4, 5);
        send_item(OP_START, 1'b0);
        long_hold_req <= 1'b1;
        steady = 1'b1;
        repeat (40) send_item(OP_TICK, 1'b0);
        steady = 1'b0;
        finish_cycle();
        wait_status_drained();
    endtask

    // Back-to-back transfers with no idling on either side
    task automatic test_back_to_back();
        load_timings(2, 3, 2, 5, 6);
        steady = 1'b1;
        repeat (4) begin
            send_item(OP_START, 1'b0);
            repeat (30) send_item(OP_TICK, $urandom_range(99) < 5);
            finish_cycle();
        end
        steady = 1'b0;
    endtask

    // Mostly well-formed cycles on random short timings, with stray starts and ticks
    task automatic test_random_cycles();
        int base;
        int pct;
        int burst;
        base = effective_items;
        while (effective_items - base < RANDOM_ITEMS) begin
            load_timings(random_ms(1), random_ms(1), random_ms(1), random_ms(0), random_ms(1));
            case ($urandom_range(3))
                0:       pct = 0;
                1:       pct = 3;
                2:       pct = 10;
                default: pct = 30;
            endcase
            burst = $urandom_range(80, 20);
            repeat (burst) begin
                if (phase_q == PH_IDLE) begin
                    if ($urandom_range(99) < 80)
                        send_item(OP_START, $urandom_range(99) < 15);
                    else
                        send_item(OP_TICK, 1'($urandom_range(1)));
                end else if ($urandom_range(99) < 4) begin
                    send_item(OP_START, 1'($urandom_range(1)));
                end else begin
                    send_item(OP_TICK, $urandom_range(99) < pct);
                end
            end
        end
    endtask

    initial begin
        timings_q.relay_pulse_ms    = RST_RELAY_PULSE;
        timings_q.opening_travel_ms = RST_OPENING_TRAVEL;
        timings_q.open_hold_ms      = RST_OPEN_HOLD;
        timings_q.clearance_ms      = RST_CLEARANCE;
        timings_q.closing_travel_ms = RST_CLOSING_TRAVEL;
        phase_q   = PH_IDLE;
        elapsed_q = '0;
        outcome_q = OUT_NONE;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_timings();
        test_directed();
        test_extreme_timings();
        test_receiver_hold();
        test_back_to_back();
        test_random_cycles();
        wait_status_drained();

        $display("Checked %0d status transfers on reset, short, longest and random timings.",
                 results_seen);
        $display("Cycles passed %0d, aborted %0d; starts refused %0d; scan warnings %0d.",
                 passes, aborts, refusals, warnings);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
